// ===== design/sliding_window_trimmed_mean_xyz_unit_macros.svh =====
// Assertion macros shared by the trimmed-mean window design.
// Depends on nothing; included by modules that carry assertions.
`ifndef SLIDING_WINDOW_TRIMMED_MEAN_XYZ_UNIT_MACROS_SVH
`define SLIDING_WINDOW_TRIMMED_MEAN_XYZ_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SWTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/swtm_pkg.sv =====
// Package for the trimmed-mean window: payload types, FSM states, cell control.
// No dependencies.
`default_nettype none
package swtm_pkg;
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] smooth_x;
		logic signed [31:0] smooth_y;
		logic signed [31:0] smooth_z;
		logic               trimmed_used;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	// Control from the sequencer to the cell row.
	typedef struct packed {
		logic push;     // shift new sample into the window
		logic load;     // copy window into sort registers
		logic sort_odd; // odd-even transposition phase
		logic sort_en;
		logic rot;      // rotate sort register toward the sum end
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/swtm_cell.sv =====
// One cell of the window row: holds one sample per axis plus a sort copy.
// Depends on swtm_pkg.
`default_nettype none
module swtm_cell
	import swtm_pkg::*;
(
	input  wire logic        clk,
	input  wire cell_ctl_t   ctl,
	input  wire in_item_t    win_in,    // from the newer neighbor
	output in_item_t         win_out,
	input  wire in_item_t    srt_left,  // lower neighbor's sort value
	input  wire in_item_t    srt_right, // higher neighbor's sort value
	input  wire in_item_t    rot_in,
	input  wire logic        is_low,    // this cell is the lower of its pair
	input  wire logic        is_high,   // this cell is the upper of its pair
	output in_item_t         srt_out
);
	in_item_t win_q;
	in_item_t srt_q;
	in_item_t srt_d;

	assign win_out = win_q;
	assign srt_out = srt_q;

	// Window shift register.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= win_in;
		end
	end

	// Compare-exchange with the pair partner, per axis.
	always_comb begin
		srt_d = srt_q;
		if (is_low) begin
			srt_d.pos_x = (srt_right.pos_x < srt_q.pos_x) ? srt_right.pos_x : srt_q.pos_x;
			srt_d.pos_y = (srt_right.pos_y < srt_q.pos_y) ? srt_right.pos_y : srt_q.pos_y;
			srt_d.pos_z = (srt_right.pos_z < srt_q.pos_z) ? srt_right.pos_z : srt_q.pos_z;
		end else if (is_high) begin
			srt_d.pos_x = (srt_left.pos_x > srt_q.pos_x) ? srt_left.pos_x : srt_q.pos_x;
			srt_d.pos_y = (srt_left.pos_y > srt_q.pos_y) ? srt_left.pos_y : srt_q.pos_y;
			srt_d.pos_z = (srt_left.pos_z > srt_q.pos_z) ? srt_left.pos_z : srt_q.pos_z;
		end
	end

	// Sort register: load, exchange or rotate.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			srt_q <= win_q;
		end else if (ctl.sort_en) begin
			srt_q <= srt_d;
		end else if (ctl.rot) begin
			srt_q <= rot_in;
		end
	end
endmodule
`default_nettype wire

// ===== design/swtm_div.sv =====
// Restoring divider: signed 40-bit sum by small unsigned count, one bit a cycle.
// Depends on swtm_pkg.
`default_nettype none
module swtm_div
	import swtm_pkg::*;
#(
	parameter int unsigned NW = 40,
	parameter int unsigned DW = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	output logic                      done,
	output logic signed [31:0]        quo
);
	// The loop runs NW+1 steps: the first only primes the remainder window.
	localparam int unsigned CW = $clog2(NW + 2);

	logic [NW-1:0] rem_q;
	logic [NW-1:0] q_q;
	logic [DW:0]   den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   part;
	logic [DW+1:0] trial;
	logic [NW-1:0] negq;

	assign part  = rem_q[NW-1 -: (DW+1)];
	assign trial = {1'b0, part} - {1'b0, den_q};
	assign negq  = neg_q ? (~q_q + 1'b1) : q_q;
	assign quo   = negq[31:0];

	// Shift-subtract loop; remainder window sits in the top bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			den_q <= {1'b0, den};
			q_q   <= num[NW-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
		end else if (busy_q) begin
			// rem/q form one shifting pair; rem keeps only DW+1 live bits
			if (!trial[DW+1]) begin
				rem_q <= {trial[DW-1:0], q_q[NW-1], {(NW-DW-1){1'b0}}} ;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {part[DW-1:0], q_q[NW-1], {(NW-DW-1){1'b0}}};
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/sliding_window_trimmed_mean_xyz_unit.sv =====
// Sliding-window trimmed mean of 3-D positions, built as a row of cells.
// Sequence: a push, then WINDOW+1 sort steps, WINDOW+1 sum steps and three serial divides
// of SW = 32 + clog2(WINDOW+1) bits each, before out_valid rises.
// One item at a time: no new sample is taken until the result item is accepted.
// Reset clears the fill count and sequencer; stored samples are not cleared.
// Depends on swtm_pkg, swtm_cell, swtm_div and the macro header.
`default_nettype none
`include "sliding_window_trimmed_mean_xyz_unit_macros.svh"
module sliding_window_trimmed_mean_xyz_unit
	import swtm_pkg::*;
#(
	parameter int unsigned WINDOW = 8,
	parameter int unsigned TRIM   = 1
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	localparam int unsigned CW = $clog2(WINDOW + 1);
	localparam int unsigned SW = 32 + CW;
	localparam int unsigned MINTRIM = 2 * TRIM + 1;

	state_t          st_q, st_d;
	logic [CW-1:0]   held_q;
	logic [CW-1:0]   step_q;
	logic [1:0]      axis_q;
	logic [1:0]      div_axis;
	logic            trim_q;
	logic [CW-1:0]   keep;
	logic signed [SW-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [SW-1:0] div_num;
	logic            div_start, div_done;
	logic signed [31:0] quo;
	logic signed [31:0] res_x_q, res_y_q;
	cell_ctl_t       ctl;
	in_item_t        win [WINDOW+1];
	in_item_t        srt [WINDOW];
	logic            take;

	// Window index 0 is the newest sample; cells beyond held are unused.
	assign win[0]   = in_data;
	assign in_ready = (st_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign keep     = trim_q ? (held_q - CW'(2 * TRIM)) : held_q;

	genvar g;
	generate
		for (g = 0; g < WINDOW; g++) begin : g_cell
			logic lo, hi;
			// Pairing only among held cells so unused ones never mix in.
			always_comb begin
				if (ctl.sort_odd) begin
					lo = (g % 2 == 1) && (g + 1 < held_q);
					hi = (g % 2 == 0) && (g >= 1) && (g < held_q);
				end else begin
					lo = (g % 2 == 0) && (g + 1 < held_q);
					hi = (g % 2 == 1) && (g < held_q);
				end
			end
			swtm_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.win_in   (win[g]),
				.win_out  (win[g+1]),
				.srt_left ((g > 0) ? srt[(g > 0) ? g-1 : 0] : srt[0]),
				.srt_right((g < WINDOW-1) ? srt[(g < WINDOW-1) ? g+1 : g] : srt[g]),
				.rot_in   (srt[(g + 1) % WINDOW]),
				.is_low   (lo),
				.is_high  (hi),
				.srt_out  (srt[g])
			);
		end
	endgenerate

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d         = st_q;
		ctl          = '0;
		ctl.sort_odd = step_q[0];
		div_start    = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (take) begin
					ctl.push = 1'b1;
					st_d     = ST_SORT;
				end
			end
			ST_SORT: begin
				ctl.load    = (step_q == '0);
				ctl.sort_en = (step_q != '0);
				if (step_q == CW'(WINDOW)) begin
					st_d = ST_SUM;
				end
			end
			ST_SUM: begin
				// The last rank is added on step WINDOW-1; the divider starts after it.
				ctl.rot = 1'b1;
				if (step_q == CW'(WINDOW)) begin
					st_d      = ST_DIV;
					div_start = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					div_start = (axis_q != 2'd2);
					if (axis_q == 2'd2) begin
						st_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Step counters, fill count and serial sums over sorted cell 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			step_q <= '0;
			axis_q <= '0;
			trim_q <= 1'b0;
		end else begin
			if (take) begin
				if (held_q != CW'(WINDOW)) begin
					held_q <= held_q + 1'b1;
					trim_q <= (CW'(MINTRIM) <= held_q + 1'b1) && (MINTRIM <= WINDOW);
				end else begin
					trim_q <= (MINTRIM <= WINDOW);
				end
				step_q <= '0;
				axis_q <= '0;
			end else if (st_q == ST_SORT) begin
				step_q <= (step_q == CW'(WINDOW)) ? '0 : step_q + 1'b1;
			end else if (st_q == ST_SUM) begin
				step_q <= step_q + 1'b1;
			end else if (st_q == ST_DIV && div_done) begin
				axis_q <= axis_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_SORT && step_q == CW'(WINDOW)) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (st_q == ST_SUM) begin
			// Cell 0 holds rank step_q; add only kept ranks.
			if (step_q < held_q && (!trim_q || (step_q >= CW'(TRIM)
					&& step_q < held_q - CW'(TRIM)))) begin
				sum_x_q <= sum_x_q + SW'(srt[0].pos_x);
				sum_y_q <= sum_y_q + SW'(srt[0].pos_y);
				sum_z_q <= sum_z_q + SW'(srt[0].pos_z);
			end
		end
	end

	// A divide started on a done cycle is for the next axis.
	assign div_axis = (st_q == ST_DIV) ? axis_q + 2'd1 : axis_q;

	always_comb begin
		case (div_axis)
			2'd0:    div_num = sum_x_q;
			2'd1:    div_num = sum_y_q;
			default: div_num = sum_z_q;
		endcase
	end

	swtm_div #(.NW(SW), .DW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (keep),
		.done   (div_done),
		.quo    (quo)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (st_q == ST_DIV && div_done) begin
			case (axis_q)
				2'd0:    res_x_q <= quo;
				2'd1:    res_y_q <= quo;
				default: begin
					out_data.smooth_x     <= res_x_q;
					out_data.smooth_y     <= res_y_q;
					out_data.smooth_z     <= quo;
					out_data.trimmed_used <= trim_q;
				end
			endcase
		end
	end

	assign out_valid = (st_q == ST_OUT);

	`SWTM_ASSERT_IMPL(a_held_range, clk, arst_n, 1'b1, held_q <= CW'(WINDOW))
	`SWTM_ASSERT_IMPL(a_no_take_busy, clk, arst_n, st_q != ST_IDLE, !in_ready)
	`SWTM_ASSERT_NEXT(a_take_sorts, clk, arst_n, take, st_q == ST_SORT)
	`SWTM_ASSERT_IMPL(a_keep_nonzero, clk, arst_n, st_q == ST_DIV, keep != '0)
endmodule
`default_nettype wire

// ===== bench/swtm_checker.sv =====
// Checker for the trimmed-mean window: watches both channels, predicts each result item.
// Depends on swtm_pkg for the payload types.
module swtm_checker
	import swtm_pkg::*;
#(
	parameter int unsigned WINDOW = 8,
	parameter int unsigned TRIM   = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending
);
	localparam int unsigned EXP_DEPTH = 64;

	logic signed [31:0] win_x [WINDOW];
	logic signed [31:0] win_y [WINDOW];
	logic signed [31:0] win_z [WINDOW];
	int unsigned held;
	int unsigned oldest;
	out_item_t exp_mem [EXP_DEPTH];
	int unsigned wr_ptr;
	int unsigned rd_ptr;

	assign pending = int'(wr_ptr - rd_ptr);

	// Mean of one axis over the held samples, trimmed when asked.
	function automatic logic signed [31:0] axis_avg(input logic signed [31:0] src [WINDOW],
			input int unsigned n, input int unsigned first, input bit trim_on);
		logic signed [31:0] buf_v [WINDOW];
		logic signed [31:0] t;
		longint sum;
		int unsigned lo, hi;
		sum = 0;
		lo = 0;
		hi = n;
		for (int i = 0; i < n; i++) buf_v[i] = src[(first + i) % WINDOW];
		if (trim_on) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j + 1 < n - i; j++)
					if (buf_v[j] > buf_v[j + 1]) begin
						t = buf_v[j];
						buf_v[j] = buf_v[j + 1];
						buf_v[j + 1] = t;
					end
			lo = TRIM;
			hi = n - TRIM;
		end
		for (int i = lo; i < hi; i++) sum += longint'(buf_v[i]);
		sum = sum / longint'(hi - lo);
		return sum[31:0];
	endfunction

	task automatic report(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int unsigned slot;
		bit trim_on;
		if (!arst_n) begin
			held <= 0;
			oldest <= 0;
			wr_ptr = 0;
			rd_ptr = 0;
		end else begin
			// Push the accepted sample and predict its result item.
			if (in_valid && in_ready) begin
				int unsigned nh, no;
				nh = held;
				no = oldest;
				if (nh < WINDOW) begin
					slot = (no + nh) % WINDOW;
					nh++;
				end else begin
					slot = no;
					no = (no + 1) % WINDOW;
				end
				win_x[slot] = in_data.pos_x;
				win_y[slot] = in_data.pos_y;
				win_z[slot] = in_data.pos_z;
				trim_on = nh >= 2 * TRIM + 1;
				want.smooth_x = axis_avg(win_x, nh, no, trim_on);
				want.smooth_y = axis_avg(win_y, nh, no, trim_on);
				want.smooth_z = axis_avg(win_z, nh, no, trim_on);
				want.trimmed_used = trim_on;
				if (wr_ptr - rd_ptr == EXP_DEPTH) begin
					report("too many result items outstanding");
				end else begin
					exp_mem[wr_ptr % EXP_DEPTH] = want;
					wr_ptr++;
				end
				held <= nh;
				oldest <= no;
			end
			// Compare each accepted result item with the oldest prediction.
			if (out_valid && out_ready) begin
				if (wr_ptr == rd_ptr) begin
					report("result item with none expected");
				end else begin
					want = exp_mem[rd_ptr % EXP_DEPTH];
					rd_ptr++;
					if (out_data.smooth_x !== want.smooth_x)
						report($sformatf("smooth_x %0d want %0d", out_data.smooth_x,
							want.smooth_x));
					if (out_data.smooth_y !== want.smooth_y)
						report($sformatf("smooth_y %0d want %0d", out_data.smooth_y,
							want.smooth_y));
					if (out_data.smooth_z !== want.smooth_z)
						report($sformatf("smooth_z %0d want %0d", out_data.smooth_z,
							want.smooth_z));
					if (out_data.trimmed_used !== want.trimmed_used)
						report($sformatf("trimmed_used %0b want %0b",
							out_data.trimmed_used, want.trimmed_used));
				end
			end
		end
	end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the trimmed-mean window: clock, reset, stimulus and verdict.
// Depends on swtm_pkg, the block under test and swtm_checker.
module tb_top;
	import swtm_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        fail_count;
	int        pending;
	int        send_idle;
	int        recv_idle;
	bit        hold_off;

	sliding_window_trimmed_mean_xyz_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	swtm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Random coordinate, weighted toward extremes and small clustered values.
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'h7fff0000 + $urandom_range(0, 65535)
				: 32'h80000000 + $urandom_range(0, 65535);
			3, 4: return $urandom;
			default: return 32'(int'($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	// Offer one input item at a falling edge and return at the falling edge after
	// its acceptance; valid stays high until the next call decides to idle.
	task automatic send_item(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= '{pos_x: x, pos_y: y, pos_z: z};
		in_valid <= 1'b1;
		while (!in_ready) @(negedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	initial begin
		#6000000;
		$display("sliding_window_trimmed_mean_xyz_unit test failed");
		$finish;
	end

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, partial window, then full window with outliers.
		send_item(32'h7fffffff, 32'h80000000, 32'h0);
		send_item(32'h7fffffff, 32'h80000000, 32'hffffffff);
		send_item(32'h80000000, 32'h7fffffff, 32'h1);
		send_item(32'hffffffff, 32'h00000001, 32'h7fffffff);
		send_item(32'h00000003, 32'hfffffffd, 32'h80000000);
		for (int i = 0; i < 12; i++)
			send_item(32'(i * 7 - 30), 32'(-i * 3), (i % 4 == 0) ? 32'h7fffffff : 32'(i));
		for (int i = 0; i < 8; i++) send_item(32'h80000000, 32'h7fffffff, 32'hffffffff);

		// Random phases with different idling; a long receiver hold-off in the last phase.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 20 : (phase == 1) ? 70 : 0;
			recv_idle = (phase == 0) ? 70 : (phase == 1) ? 20 : 0;
			for (int i = 0; i < 130; i++) begin
				if (phase == 2 && i == 10) begin
					fork
						begin
							@(negedge clk);
							hold_off <= 1'b1;
							repeat (600) @(negedge clk);
							hold_off <= 1'b0;
						end
					join_none
				end
				send_item(pick_coord(), pick_coord(), pick_coord());
			end
		end
		in_valid <= 1'b0;

		// Drain, then let the block settle.
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("sliding_window_trimmed_mean_xyz_unit test passed");
		end else begin
			$display("sliding_window_trimmed_mean_xyz_unit test failed");
		end
		$finish;
	end
endmodule

// ===== sliding_window_trimmed_mean_xyz_unit.f =====
+incdir+design
design/swtm_pkg.sv
design/swtm_cell.sv
design/swtm_div.sv
design/sliding_window_trimmed_mean_xyz_unit.sv
bench/swtm_checker.sv
bench/tb_top.sv
